FILE: rtl/core/srle_pkg.sv
`default_nettype none

package srle_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int FILL_W      = 7;
    localparam int SIDE_W      = 13;
    localparam int SIDE_MAX    = 2 ** SIDE_W - 1;
    localparam int LEFT_W      = 7;
    localparam int RUN_BIAS    = 3;
    localparam int PIX8_WORD   = 8;
    localparam int CNT_W       = 11;
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DEFAULT_MAX_SIDE = 4096;

    // Register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Decode modes.
    localparam logic [1:0] MODE_RAW  = 2'd0;
    localparam logic [1:0] MODE_RLE8 = 2'd1;
    localparam logic [1:0] MODE_RLE1 = 2'd2;
    localparam logic [1:0] MODE_OFF  = 2'd3;

    // Parser state of the RLE stream.
    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_RUN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } byte_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic [FILL_W-1:0] pixel_count;
        logic              frame_last;
    } pixel_item_t;

    // One classified byte: pixels to pack, already cut at the frame end.
    typedef struct packed {
        logic              clear;
        logic [BYTE_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              ends;
    } cmd_t;

    // A side of zero counts as one, a side above the limit as the limit.
    function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v,
                                                     input int max_side);
        logic [SIDE_W-1:0] r;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (int'(v) > max_side)
        begin
            r = SIDE_W'(max_side);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srle_cfg.sv
`default_nettype none

module srle_cfg #(
    parameter int MAX_SIDE = srle_pkg::DEFAULT_MAX_SIDE,
    parameter int TOTAL_W  = 25
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [srle_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [srle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [srle_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [1:0]                        mode,
    output logic      [TOTAL_W-1:0]                total,
    output logic                                   clr
);

    localparam int SideW = srle_pkg::SIDE_W;
    localparam int DataW = srle_pkg::APB_DATA_W;

    logic [1:0]         mode_reg;
    logic [SideW-1:0]   width_reg;
    logic [SideW-1:0]   height_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               wr;
    logic [1:0]         idx;
    logic [SideW-1:0]   mul_a;
    logic [SideW-1:0]   mul_b;
    logic [2*SideW-1:0] product;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign clr    = wr && (idx == srle_pkg::REG_MODE);
    assign mode   = mode_reg;
    assign total  = total_reg;

    // The frame size is multiplied out as a side is written.
    always_comb
    begin
        mul_a = srle_pkg::side_clamp(width_reg, MAX_SIDE);
        mul_b = srle_pkg::side_clamp(height_reg, MAX_SIDE);
        if (idx == srle_pkg::REG_WIDTH)
        begin
            mul_a = srle_pkg::side_clamp(pwdata[SideW-1:0], MAX_SIDE);
        end
        else if (idx == srle_pkg::REG_HEIGHT)
        begin
            mul_b = srle_pkg::side_clamp(pwdata[SideW-1:0], MAX_SIDE);
        end
        product    = mul_a * mul_b;
        total_next = product[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= srle_pkg::MODE_RLE8;
            width_reg  <= SideW'(1);
            height_reg <= SideW'(1);
            total_reg  <= TOTAL_W'(1);
        end
        else if (wr)
        begin
            case (idx)
                srle_pkg::REG_MODE:
                begin
                    mode_reg <= pwdata[1:0];
                end
                srle_pkg::REG_WIDTH:
                begin
                    width_reg <= pwdata[SideW-1:0];
                    total_reg <= total_next;
                end
                srle_pkg::REG_HEIGHT:
                begin
                    height_reg <= pwdata[SideW-1:0];
                    total_reg  <= total_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (idx)
            srle_pkg::REG_MODE:   prdata = DataW'(mode_reg);
            srle_pkg::REG_WIDTH:  prdata = DataW'(width_reg);
            srle_pkg::REG_HEIGHT: prdata = DataW'(height_reg);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/srle_front.sv
`default_nettype none

module srle_front #(
    parameter int TOTAL_W = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clr,
    input  wire logic [1:0]           mode,
    input  wire logic [TOTAL_W-1:0]   total,
    input  wire logic                 accept,
    input  wire srle_pkg::byte_item_t item,
    output logic                      cmd_valid,
    output srle_pkg::cmd_t            cmd
);

    localparam int CntW  = srle_pkg::CNT_W;
    localparam int LeftW = srle_pkg::LEFT_W;
    localparam int CmpW  = (TOTAL_W > CntW) ? TOTAL_W : CntW;

    srle_pkg::phase_t   phase_reg;
    srle_pkg::phase_t   phase_next;
    srle_pkg::phase_t   phase_eff;
    logic [LeftW-1:0]   left_reg;
    logic [LeftW-1:0]   left_next;
    logic [LeftW-1:0]   left_eff;
    logic [TOTAL_W-1:0] done_reg;
    logic [TOTAL_W-1:0] done_next;
    logic [TOTAL_W-1:0] done_eff;
    logic [TOTAL_W-1:0] remaining;
    logic               live;
    logic               has_pixels;
    logic [7:0]         n_bytes;
    logic [CntW-1:0]    n_pixels;
    logic [CntW-1:0]    take;
    logic               ends;
    logic [7:0]         b;

    // A frame start byte sees a freshly cleared decoder.
    assign b         = item.data_byte;
    assign phase_eff = item.frame_start ? srle_pkg::PH_CTRL : phase_reg;
    assign left_eff  = item.frame_start ? '0 : left_reg;
    assign done_eff  = item.frame_start ? '0 : done_reg;
    assign live      = accept && (mode != srle_pkg::MODE_OFF) && (done_eff < total);

    // Data bytes carry pixels; a control byte only sets up the next ones.
    assign has_pixels = live && ((mode == srle_pkg::MODE_RAW) || (phase_eff != srle_pkg::PH_CTRL));
    assign n_bytes    = (mode != srle_pkg::MODE_RAW && phase_eff == srle_pkg::PH_RUN)
                      ? 8'(left_eff) + 8'(srle_pkg::RUN_BIAS) : 8'd1;
    assign n_pixels   = (mode == srle_pkg::MODE_RLE1) ? {n_bytes, 3'b000} : CntW'(n_bytes);
    assign remaining  = total - done_eff;
    assign ends       = CmpW'(n_pixels) >= CmpW'(remaining);
    assign take       = ends ? CntW'(remaining) : n_pixels;

    // Parser next state.
    always_comb
    begin
        phase_next = phase_eff;
        left_next  = left_eff;
        done_next  = done_eff;
        if (has_pixels)
        begin
            done_next = done_eff + TOTAL_W'(take);
        end
        if (live && mode != srle_pkg::MODE_RAW)
        begin
            case (phase_eff)
                srle_pkg::PH_LIT:
                begin
                    if (left_eff == '0)
                    begin
                        phase_next = srle_pkg::PH_CTRL;
                    end
                    else
                    begin
                        left_next = left_eff - LeftW'(1);
                    end
                end
                srle_pkg::PH_RUN:
                begin
                    left_next  = '0;
                    phase_next = srle_pkg::PH_CTRL;
                end
                default:
                begin
                    // Negative control: -N literals, kept as N minus one.
                    if (b[7])
                    begin
                        left_next  = ~b[LeftW-1:0];
                        phase_next = srle_pkg::PH_LIT;
                    end
                    else
                    begin
                        left_next  = b[LeftW-1:0];
                        phase_next = srle_pkg::PH_RUN;
                    end
                end
            endcase
        end
    end

    // Command to the packer.
    always_comb
    begin
        cmd_valid = accept && (item.frame_start || has_pixels);
        cmd.clear = item.frame_start;
        cmd.value = b;
        cmd.count = has_pixels ? take : '0;
        cmd.ends  = has_pixels && ends;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= srle_pkg::PH_CTRL;
            left_reg  <= '0;
            done_reg  <= '0;
        end
        else if (clr)
        begin
            phase_reg <= srle_pkg::PH_CTRL;
            left_reg  <= '0;
            done_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/srle_fifo.sv
`default_nettype none

module srle_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clr,
    input  wire logic           wr,
    input  wire srle_pkg::cmd_t wr_data,
    output logic                full,
    input  wire logic           rd,
    output srle_pkg::cmd_t      rd_data,
    output logic                empty
);

    localparam int Depth = srle_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    srle_pkg::cmd_t  entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (clr)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The front only writes into free space and the packer only reads a stored entry.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr && full))
        else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd && empty))
        else $error("command queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/core/srle_back.sv
`default_nettype none

module srle_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clr,
    input  wire logic [1:0]     mode,
    input  wire srle_pkg::cmd_t q_data,
    input  wire logic           q_empty,
    output logic                q_pop,
    output srle_pkg::pixel_item_t result,
    output logic                empty,
    input  wire logic           pop
);

    localparam int CntW  = srle_pkg::CNT_W;
    localparam int FillW = srle_pkg::FILL_W;
    localparam int WordW = srle_pkg::WORD_W;
    localparam int ByteW = srle_pkg::BYTE_W;
    localparam int Lanes = srle_pkg::PIX8_WORD;

    logic                  active_reg;
    logic                  active_next;
    logic [ByteW-1:0]      val_reg;
    logic [ByteW-1:0]      val_next;
    logic [CntW-1:0]       left_reg;
    logic [CntW-1:0]       left_next;
    logic                  ends_reg;
    logic                  ends_next;
    logic [2:0]            rot_reg;
    logic [2:0]            rot_next;
    logic [WordW-1:0]      acc_reg;
    logic [WordW-1:0]      acc_next;
    logic [FillW-1:0]      fill_reg;
    logic [FillW-1:0]      fill_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    srle_pkg::pixel_item_t out_reg;
    srle_pkg::pixel_item_t out_next;

    logic             one_bit;
    logic [FillW-1:0] cap;
    logic [FillW-1:0] room;
    logic [FillW-1:0] take;
    logic [FillW-1:0] new_fill;
    logic             last_here;
    logic             emit;
    logic             step;
    logic             load;
    logic             popped;
    logic [ByteW-1:0] pattern;
    logic [WordW-1:0] add_word;
    logic [FillW-1:0] fill0;
    logic [2:0]       idx3;

    assign one_bit  = (mode == srle_pkg::MODE_RLE1);
    assign cap      = one_bit ? FillW'(WordW) : FillW'(Lanes);
    assign room     = cap - fill_reg;
    assign take     = (CntW'(room) > left_reg) ? left_reg[FillW-1:0] : room;
    assign new_fill = fill_reg + take;
    assign last_here = ends_reg && (left_reg == CntW'(take));
    assign emit     = (new_fill == cap) || last_here;
    assign popped   = pop && out_valid_reg;
    assign step     = active_reg && (!emit || !out_valid_reg || pop);
    assign load     = !active_reg && !q_empty;
    assign q_pop    = load && !clr;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    // Pixels placed this cycle: positions from fill up to the new fill.
    always_comb
    begin
        for (int j = 0; j < ByteW; j++)
        begin
            idx3       = 3'(j) + rot_reg;
            pattern[j] = val_reg[idx3];
        end
        add_word = '0;
        if (one_bit)
        begin
            for (int p = 0; p < WordW; p++)
            begin
                if (FillW'(p) >= fill_reg && FillW'(p) < new_fill)
                begin
                    add_word[p] = pattern[p % ByteW];
                end
            end
        end
        else
        begin
            for (int j = 0; j < Lanes; j++)
            begin
                if (FillW'(j) >= fill_reg && FillW'(j) < new_fill)
                begin
                    add_word[j*ByteW +: ByteW] = val_reg;
                end
            end
        end
    end

    // Packer next state.
    always_comb
    begin
        active_next    = active_reg;
        val_next       = val_reg;
        left_next      = left_reg;
        ends_next      = ends_reg;
        rot_next       = rot_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !popped;
        out_next       = out_reg;
        fill0          = q_data.clear ? '0 : fill_reg;
        if (clr)
        begin
            active_next = 1'b0;
            acc_next    = '0;
            fill_next   = '0;
        end
        else if (load)
        begin
            if (q_data.clear)
            begin
                acc_next  = '0;
                fill_next = '0;
            end
            val_next    = q_data.value;
            left_next   = q_data.count;
            ends_next   = q_data.ends;
            rot_next    = 3'd0 - fill0[2:0];
            active_next = (q_data.count != '0);
        end
        else if (step)
        begin
            left_next   = left_reg - CntW'(take);
            active_next = (left_reg != CntW'(take));
            if (emit)
            begin
                out_next.pixel_word  = acc_reg | add_word;
                out_next.pixel_count = new_fill;
                out_next.frame_last  = last_here;
                out_valid_next       = 1'b1;
                acc_next             = '0;
                fill_next            = '0;
            end
            else
            begin
                acc_next  = acc_reg | add_word;
                fill_next = new_fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            acc_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        left_reg <= left_next;
        ends_reg <= ends_next;
        rot_reg  <= rot_next;
        out_reg  <= out_next;
    end

    a_fill_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        !one_bit |-> fill_reg < FillW'(Lanes))
        else $error("byte packer fill passed a full word");
    a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> left_reg != '0)
        else $error("packer busy with no pixels left");
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.pixel_count != '0 && out_reg.pixel_count <= cap)
        else $error("result word with a bad pixel count");

endmodule

`default_nettype wire

FILE: rtl/core/sprite_rle_decoder.sv
`default_nettype none

// Channel    Handshake            Payload                               Transfer when
// input      push / full          byte_item  (data_byte, frame_start)   push && !full
// result     empty / pop          pixel_item (pixel_word, count, last)  pop && !empty
// config     psel / penable       paddr, pwdata, prdata                 psel && penable && pwrite
//
// A byte is classified as it is accepted and written into the command queue; the packer
// takes a command only while idle and then works through the ceil((fill + pixels) / word)
// words it touches, one word per cycle while the output register is free or being popped.
// The packer's one-word-per-cycle datapath and its single output register set the rate.
// Reset is asynchronous and active low; a mode write also clears the decoder.
// When the result is not taken the packer holds, the queue fills and full rises.

module sprite_rle_decoder #(
    parameter int MAX_SIDE = srle_pkg::DEFAULT_MAX_SIDE
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire srle_pkg::byte_item_t            byte_item,
    output logic                                 empty,
    input  wire logic                            pop,
    output srle_pkg::pixel_item_t                pixel_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srle_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [srle_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [srle_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int SIDE_EFF = (MAX_SIDE < srle_pkg::SIDE_MAX) ? MAX_SIDE : srle_pkg::SIDE_MAX;
    localparam int TOTAL_W  = $clog2(SIDE_EFF * SIDE_EFF + 1);

    logic [1:0]         mode;
    logic [TOTAL_W-1:0] total;
    logic               clr;
    logic               accept;
    logic               cmd_valid;
    srle_pkg::cmd_t     cmd;
    srle_pkg::cmd_t     q_data;
    logic               q_empty;
    logic               q_pop;

    assign accept = push && !full;

    srle_cfg #(
        .MAX_SIDE (MAX_SIDE),
        .TOTAL_W  (TOTAL_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .total   (total),
        .clr     (clr)
    );

    srle_front #(
        .TOTAL_W (TOTAL_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .mode      (mode),
        .total     (total),
        .accept    (accept),
        .item      (byte_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    srle_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr),
        .wr      (cmd_valid),
        .wr_data (cmd),
        .full    (full),
        .rd      (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    srle_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr),
        .mode    (mode),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (pixel_item),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire

FILE: test/tb_sprite_rle_decoder.sv
`timescale 1ns / 100ps

module tb_sprite_rle_decoder;

    localparam int FRAME_SIDE_MAX = srle_pkg::DEFAULT_MAX_SIDE;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_BYTES    = 45;

    // Predicts the pixel words of the decoder and checks the ones that come out.
    class pixel_scoreboard;
        logic [1:0]            mode;
        logic [12:0]           width;
        logic [12:0]           height;
        srle_pkg::phase_t      phase;
        int                    left;
        logic [63:0]           acc;
        int                    fill;
        int                    done;
        srle_pkg::pixel_item_t words_due[$];
        int                    errors;

        function new();
            mode   = srle_pkg::MODE_RLE8;
            width  = 13'd1;
            height = 13'd1;
            errors = 0;
            clear_decoder();
        endfunction

        function void clear_decoder();
            phase = srle_pkg::PH_CTRL;
            left  = 0;
            acc   = '0;
            fill  = 0;
            done  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == srle_pkg::REG_MODE)
            begin
                mode = val[1:0];
                clear_decoder();
            end
            else if (idx == srle_pkg::REG_WIDTH)
            begin
                width = val[12:0];
            end
            else if (idx == srle_pkg::REG_HEIGHT)
            begin
                height = val[12:0];
            end
        endfunction

        function int clamp_side(logic [12:0] v);
            if (v == '0)
                return 1;
            if (int'(v) > FRAME_SIDE_MAX)
                return FRAME_SIDE_MAX;
            return int'(v);
        endfunction

        function int frame_pixels();
            return clamp_side(width) * clamp_side(height);
        endfunction

        // Add one pixel to the word being built; a full word or the frame end emits it.
        function void pack_pixel(logic [63:0] v, int bits, int cap, int total);
            srle_pkg::pixel_item_t w;
            if (done >= total || fill >= cap)
                return;
            acc = acc | (v << (fill * bits));
            fill++;
            done++;
            if (fill == cap || done == total)
            begin
                w.pixel_word  = acc;
                w.pixel_count = srle_pkg::FILL_W'(fill);
                w.frame_last  = (done == total);
                words_due.push_back(w);
                acc  = '0;
                fill = 0;
            end
        endfunction

        // One decoded byte is one 8-bit pixel or eight 1-bit pixels, LSB first.
        function void unpack_byte(logic [7:0] b, int total);
            int i;
            if (mode == srle_pkg::MODE_RLE1)
            begin
                for (i = 0; i < 8; i++)
                    pack_pixel(64'(b[i]), 1, 64, total);
            end
            else
            begin
                pack_pixel(64'(b), 8, 8, total);
            end
        endfunction

        // Called for every accepted input transfer.
        function void note_byte(srle_pkg::byte_item_t it);
            int total;
            int n;
            logic [7:0] b;
            b = it.data_byte;
            if (it.frame_start)
                clear_decoder();
            total = frame_pixels();
            if (mode == srle_pkg::MODE_OFF || done >= total)
                return;
            if (mode == srle_pkg::MODE_RAW)
            begin
                unpack_byte(b, total);
                return;
            end
            case (phase)
                srle_pkg::PH_LIT:
                begin
                    unpack_byte(b, total);
                    if (left == 0)
                        phase = srle_pkg::PH_CTRL;
                    else
                        left--;
                end
                srle_pkg::PH_RUN:
                begin
                    for (n = 0; n < left + srle_pkg::RUN_BIAS; n++)
                        unpack_byte(b, total);
                    left  = 0;
                    phase = srle_pkg::PH_CTRL;
                end
                default:
                begin
                    if (b[7])
                    begin
                        // Negative control: copy -N bytes, kept as N-1.
                        left  = ((256 - int'(b)) - 1) & 'h7F;
                        phase = srle_pkg::PH_LIT;
                    end
                    else
                    begin
                        left  = int'(b[6:0]);
                        phase = srle_pkg::PH_RUN;
                    end
                end
            endcase
        endfunction

        // Called for every accepted result transfer.
        function void check_word(srle_pkg::pixel_item_t got);
            srle_pkg::pixel_item_t want;
            if (words_due.size() == 0)
            begin
                $error("pixel word with none expected: pixel_word %h", got.pixel_word);
                errors++;
                return;
            end
            want = words_due.pop_front();
            if (got.pixel_word !== want.pixel_word)
            begin
                $error("pixel_word: expected %h, actual %h", want.pixel_word, got.pixel_word);
                errors++;
            end
            if (got.pixel_count !== want.pixel_count)
            begin
                $error("pixel_count: expected %0d, actual %0d",
                       want.pixel_count, got.pixel_count);
                errors++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    srle_pkg::byte_item_t            byte_item = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    srle_pkg::pixel_item_t           pixel_item;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [srle_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [srle_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [srle_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    pixel_scoreboard      frames;
    srle_pkg::byte_item_t byte_plan[$];
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    bit                   long_hold_req = 1'b0;
    int                   cycle_count = 0;
    logic [1:0]           cur_mode = srle_pkg::MODE_RLE8;

    sprite_rle_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_item  (byte_item),
        .empty      (empty),
        .pop        (pop),
        .pixel_item (pixel_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: checks each transfer and stalls in random bursts.
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                frames.check_word(pixel_item);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Register write: setup, then access until pready, then back to idle.
    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srle_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic void plan_byte(logic [7:0] b, logic fs);
        srle_pkg::byte_item_t it;
        it.data_byte   = b;
        it.frame_start = fs;
        byte_plan.push_back(it);
    endfunction

    // Input side: offers the planned bytes, with random gaps between transfers.
    task automatic send_plan();
        srle_pkg::byte_item_t it;
        while (byte_plan.size() != 0)
        begin
            it = byte_plan.pop_front();
            if (tx_idle_on && $urandom_range(0, 5) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            push      <= 1'b1;
            byte_item <= it;
            do
                @(posedge clk);
            while (full);
            frames.note_byte(it);
        end
    endtask

    // Stop offering, wait for every expected word, then let the block settle.
    task automatic drain();
        push <= 1'b0;
        while (frames.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame of well-formed packets with random content, sometimes cut short.
    task automatic plan_frame(logic [1:0] mode, int pixels, int budget);
        int want;
        int got;
        int per;
        int n;
        logic fs;
        fs   = 1'b1;
        got  = 0;
        want = (pixels > 200) ? $urandom_range(8, 200) : pixels;
        per  = (mode == srle_pkg::MODE_RLE1) ? 8 : 1;
        while (got < want && byte_plan.size() < budget)
        begin
            if (mode == srle_pkg::MODE_RAW)
            begin
                plan_byte(8'($urandom), fs);
                got++;
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                n = ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 12);
                plan_byte(8'(n), fs);
                plan_byte(8'($urandom), 1'b0);
                got += (n + srle_pkg::RUN_BIAS) * per;
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
                plan_byte(8'(256 - n), fs);
                repeat (n) plan_byte(8'($urandom), 1'b0);
                got += n * per;
            end
            fs = 1'b0;
            if ($urandom_range(0, 15) == 0)
                break;
        end
    endtask

    initial
    begin : main_flow
        int p;
        int r;
        logic [12:0] w;
        logic [12:0] h;
        frames = new();

        // Reset.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings, one-pixel frame; bytes after the frame end are ignored.
        plan_byte(8'h00, 1'b1);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h55, 1'b0);
        send_plan();
        drain();

        // Zero height counts as one; a literal of one byte, then a maximal run cut at the end.
        apb_write(srle_pkg::REG_WIDTH, 32'd3);
        apb_write(srle_pkg::REG_HEIGHT, 32'd0);
        plan_byte(8'hFF, 1'b1);
        plan_byte(8'h00, 1'b0);
        plan_byte(8'h7F, 1'b0);
        plan_byte(8'h80, 1'b0);
        send_plan();
        drain();

        // Raw mode, oversized width; a frame start in mid frame drops the partial word.
        apb_write(srle_pkg::REG_MODE, 32'(srle_pkg::MODE_RAW));
        apb_write(srle_pkg::REG_WIDTH, 32'h1FFF);
        apb_write(srle_pkg::REG_HEIGHT, 32'd1);
        plan_byte(8'h00, 1'b1);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h80, 1'b0);
        plan_byte(8'h7F, 1'b0);
        plan_byte(8'h01, 1'b0);
        plan_byte(8'hFE, 1'b0);
        plan_byte(8'hAA, 1'b0);
        plan_byte(8'h55, 1'b0);
        plan_byte(8'h11, 1'b0);
        plan_byte(8'h22, 1'b1);
        send_plan();
        drain();

        // 1-bit mode: a longest run on top of a partial word gives seventeen words.
        apb_write(srle_pkg::REG_MODE, 32'(srle_pkg::MODE_RLE1));
        apb_write(srle_pkg::REG_WIDTH, 32'd64);
        apb_write(srle_pkg::REG_HEIGHT, 32'd20);
        plan_byte(8'h01, 1'b1);
        plan_byte(8'hC3, 1'b0);
        plan_byte(8'hFE, 1'b0);
        plan_byte(8'h0F, 1'b0);
        plan_byte(8'hF0, 1'b0);
        plan_byte(8'h7F, 1'b0);
        plan_byte(8'hA5, 1'b0);
        send_plan();
        drain();

        // Shrinking the frame below what was decoded completes it; later bytes are ignored.
        apb_write(srle_pkg::REG_HEIGHT, 32'd1);
        plan_byte(8'h00, 1'b0);
        plan_byte(8'h3C, 1'b0);
        send_plan();
        drain();
        cur_mode = srle_pkg::MODE_RLE1;

        // Random phases, each with its own settings; the last one runs without idling.
        for (p = 0; p < 8; p++)
        begin
            if (p == 7)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (p == 1 || p == 3 || $urandom_range(0, 3) != 0)
            begin
                r = $urandom_range(0, 9);
                if (p == 1)
                    cur_mode = srle_pkg::MODE_OFF;
                else if (p == 3)
                    cur_mode = srle_pkg::MODE_RLE8;
                else if (r < 2)
                    cur_mode = srle_pkg::MODE_RAW;
                else if (r < 5)
                    cur_mode = srle_pkg::MODE_RLE8;
                else if (r < 9)
                    cur_mode = srle_pkg::MODE_RLE1;
                else
                    cur_mode = srle_pkg::MODE_OFF;
                apb_write(srle_pkg::REG_MODE, 32'(cur_mode));
            end
            w = (cur_mode == srle_pkg::MODE_RLE1) ? 13'($urandom_range(1, 160))
                                                  : 13'($urandom_range(1, 24));
            h = 13'($urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0)
                w = 13'($urandom_range(0, 8191));
            if ($urandom_range(0, 7) == 0)
                h = 13'($urandom_range(0, 8191));
            apb_write(srle_pkg::REG_WIDTH, 32'(w));
            apb_write(srle_pkg::REG_HEIGHT, 32'(h));

            // Mostly whole frames, with some stray bytes in between.
            while (byte_plan.size() < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                    plan_byte(8'($urandom), 1'($urandom_range(0, 1)));
                else
                    plan_frame(cur_mode, frames.frame_pixels(), PHASE_BYTES);
            end

            // The receiver holds off for a long stretch so the input backs up.
            if (p == 3)
                long_hold_req = 1'b1;
            send_plan();
            drain();
        end

        if (frames.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/srle_pkg.sv
rtl/core/srle_cfg.sv
rtl/core/srle_front.sv
rtl/core/srle_fifo.sv
rtl/core/srle_back.sv
rtl/core/sprite_rle_decoder.sv
test/tb_sprite_rle_decoder.sv
